@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define VKS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define VKS_ASSERT(lbl, prop, msg) `VKS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ design/vks_pkg.sv @@
`timescale 1ns / 1ps

package vks_pkg;

  // Full turn in Q9.16 degrees.
  localparam logic [24:0] HEAD_MOD = 25'd23592960;
  // Magnitudes up to this value (Q8.8) snap to zero.
  localparam int SNAP_LIM = 25;

  localparam logic [2:0] CFG_FWD_SPEED = 3'd0;
  localparam logic [2:0] CFG_BWD_SPEED = 3'd1;
  localparam logic [2:0] CFG_LEFT_STEER = 3'd2;
  localparam logic [2:0] CFG_RIGHT_STEER = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAG_SPD,
    ST_LAG_STR,
    ST_MUL_D,
    ST_MUL_H1,
    ST_MUL_H2,
    ST_HEAD_SUM,
    ST_CORDIC_WAIT,
    ST_MUL_X,
    ST_MUL_Z,
    ST_Z_SUM,
    ST_FINISH
  } seq_state_e;

  // Arctangent of 2^-i in Q.24 degrees.
  function automatic logic signed [33:0] atan_q24(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0: r = 34'sd754974720;
      5'd1: r = 34'sd445687602;
      5'd2: r = 34'sd235489088;
      5'd3: r = 34'sd119537938;
      5'd4: r = 34'sd60000934;
      5'd5: r = 34'sd30029717;
      5'd6: r = 34'sd15018523;
      5'd7: r = 34'sd7509720;
      5'd8: r = 34'sd3754917;
      5'd9: r = 34'sd1877466;
      5'd10: r = 34'sd938734;
      5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;
      5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;
      5'd15: r = 34'sd29336;
      5'd16: r = 34'sd14668;
      5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;
      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;
      5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;
      5'd23: r = 34'sd115;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/vks_cordic.sv @@
`timescale 1ns / 1ps

// Iterative CORDIC rotation: one micro-rotation per cycle.
module vks_cordic #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [24:0]         head_i,
  output logic                done_o,
  output logic signed [32:0]  cos_o,
  output logic signed [32:0]  sin_o
);

  localparam int CW = $clog2(CORDIC_ITERS);
  localparam logic signed [33:0] HALF = 34'sd180 <<< 24;
  localparam logic signed [33:0] QUARTER = 34'sd90 <<< 24;
  localparam logic signed [32:0] X_INIT = 33'sd652032874;

  logic signed [32:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d, neg_q, neg_d;

  always_comb begin
    logic signed [33:0] zs;
    logic signed [32:0] dx, dy;
    logic signed [33:0] at;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    neg_d = neg_q;
    zs = signed'({1'b0, head_i, 8'd0});
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    at = vks_pkg::atan_q24(5'(cnt_q));
    if (start_i) begin
      if (zs > HALF) begin
        zs = zs - (HALF <<< 1);
      end
      neg_d = 1'b0;
      if (zs > QUARTER) begin
        zs = zs - HALF;
        neg_d = 1'b1;
      end else if (zs < -QUARTER) begin
        zs = zs + HALF;
        neg_d = 1'b1;
      end
      z_d = zs;
      x_d = X_INIT;
      y_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      if (cnt_q == CW'(CORDIC_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign cos_o = neg_q ? -x_q : x_q;
  assign sin_o = neg_q ? -y_q : y_q;

endmodule

@@ design/vks_wrap.sv @@
`timescale 1ns / 1ps

// Heading wrap into the turn range by restoring compare-subtract,
// one multiple of the turn per cycle.
module vks_wrap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] head_i,
  output logic               done_o,
  output logic [24:0]        head_o
);

  localparam logic [32:0] MOD33 = {8'd0, vks_pkg::HEAD_MOD};

  logic [31:0] v_q, v_d;
  logic [2:0]  k_q, k_d;
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [24:0] res_q, res_d;

  always_comb begin
    logic [32:0] sub;
    logic [31:0] vn;
    v_d = v_q;
    k_d = k_q;
    busy_d = busy_q;
    done_d = done_q;
    neg_d = neg_q;
    res_d = res_q;
    sub = MOD33 << k_q;
    vn = ({1'b0, v_q} >= sub) ? 32'({1'b0, v_q} - sub) : v_q;
    if (start_i) begin
      k_d = 3'd6;
      done_d = 1'b0;
      if (head_i > signed'({9'd0, vks_pkg::HEAD_MOD})) begin
        v_d = 32'(head_i - 34'sd1);
        neg_d = 1'b0;
        busy_d = 1'b1;
      end else if (head_i < 0) begin
        v_d = 32'(-head_i);
        neg_d = 1'b1;
        busy_d = 1'b1;
      end else begin
        res_d = 25'(head_i);
        done_d = 1'b1;
      end
    end else if (busy_q) begin
      v_d = vn;
      if (k_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          res_d = (vn == 32'd0) ? 25'd0 : 25'(vks_pkg::HEAD_MOD - 25'(vn));
        end else begin
          res_d = 25'(vn + 32'd1);
        end
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign head_o = res_q;

endmodule

@@ design/vehicle_kinematic_step_core.sv @@
`timescale 1ns / 1ps
// A request runs through the sequencer to its result before the next is taken; the
// latency is set by the iterative CORDIC rotation unit and the position steps.
// The next request waits until the last result is committed to the result
// register, which is free once its result is taken; in_ready_o is high only in idle.
// Reset: asynchronous active low; the vehicle state clears to zero and the
// limit registers return to +10 m/s, -2 m/s, -30 deg and +30 deg.

// Dead-reckoning update core. A small sequencer drives a single shared
// 33x33 multiplier through the lag, distance, heading and position products.
// The CORDIC unit starts at acceptance on the old heading and runs alongside
// the multiply steps; the heading wrap unit starts as soon as the new
// heading sum is known. A result register decouples the output request so
// the next input can be taken while a result waits.
module vehicle_kinematic_step_core #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] target_speed_i,
  input  logic signed [15:0] target_steer_i,
  input  logic [15:0]        step_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_z_o,
  output logic [24:0]        heading_o,
  output logic signed [15:0] cur_speed_o,
  output logic signed [15:0] cur_steer_o
);

  // Clamp to two bounds given in either order.
  function automatic logic signed [15:0] clamp(input logic signed [15:0] a,
                                               input logic signed [21:0] n,
                                               input logic signed [15:0] b);
    logic signed [21:0] lo, hi, r;
    lo = (a < b) ? 22'(a) : 22'(b);
    hi = (a < b) ? 22'(b) : 22'(a);
    r = n;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return 16'(r);
  endfunction

  function automatic logic signed [15:0] snap(input logic signed [15:0] v);
    return (v >= -16'(vks_pkg::SNAP_LIM) && v <= 16'(vks_pkg::SNAP_LIM)) ? 16'sd0 : v;
  endfunction

  vks_pkg::seq_state_e state_q, state_d;

  // Limit registers.
  logic signed [15:0] fwd_q, bwd_q, left_q, right_q;

  // Vehicle state.
  logic signed [15:0] speed_q, steer_q;
  logic signed [31:0] x_q, z_q;
  logic [24:0]        head_q;

  // Per-request working registers.
  logic signed [15:0] tsp_q, tst_q;
  logic [15:0]        dt_q;
  logic signed [15:0] sp_q, sp_d, st_q, st_d;
  logic signed [31:0] d_q, d_d, xn_q, xn_d, zn_q, zn_d;
  logic signed [65:0] prod_q, prod_d;

  // Result register.
  logic               ovalid_q;
  logic signed [31:0] ox_q, oz_q;
  logic [24:0]        ohead_q;
  logic signed [15:0] ospeed_q, osteer_q;

  logic signed [32:0] mul_a, mul_b;
  logic               accept, commit;
  logic               cordic_done, wrap_start, wrap_done;
  logic signed [32:0] cos_w, sin_w;
  logic signed [33:0] head_sum;
  logic [24:0]        head_wrapped;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == vks_pkg::ST_IDLE);

  vks_cordic #(
    .CORDIC_ITERS(CORDIC_ITERS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .head_i (head_q),
    .done_o (cordic_done),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  vks_wrap u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wrap_start),
    .head_i (head_sum),
    .done_o (wrap_done),
    .head_o (head_wrapped)
  );

  // Heading increment is the rounded dt*steer*speed product.
  assign head_sum = signed'({9'd0, head_q}) + 34'((prod_q + 66'sd32768) >>> 16);

  always_comb begin
    logic signed [65:0] rs;
    state_d = state_q;
    sp_d = sp_q;
    st_d = st_q;
    d_d = d_q;
    xn_d = xn_q;
    zn_d = zn_q;
    mul_a = '0;
    mul_b = '0;
    wrap_start = 1'b0;
    commit = 1'b0;
    rs = '0;
    case (state_q)
      vks_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = vks_pkg::ST_LAG_SPD;
        end
      end
      vks_pkg::ST_LAG_SPD: begin
        mul_a = 33'(tsp_q) - 33'(speed_q);
        mul_b = signed'({17'd0, dt_q});
        state_d = vks_pkg::ST_LAG_STR;
      end
      vks_pkg::ST_LAG_STR: begin
        // Speed lag gain of four, rounded half up.
        rs = ((prod_q <<< 2) + 66'sd32768) >>> 16;
        sp_d = clamp(bwd_q, 22'(speed_q) + 22'(rs), fwd_q);
        mul_a = 33'(tst_q) - 33'(steer_q);
        mul_b = signed'({17'd0, dt_q});
        state_d = vks_pkg::ST_MUL_D;
      end
      vks_pkg::ST_MUL_D: begin
        // Steering lag gain of six.
        rs = ((prod_q * 66'sd6) + 66'sd32768) >>> 16;
        st_d = clamp(left_q, 22'(steer_q) + 22'(rs), right_q);
        mul_a = 33'(sp_q);
        mul_b = signed'({17'd0, dt_q});
        state_d = vks_pkg::ST_MUL_H1;
      end
      vks_pkg::ST_MUL_H1: begin
        // Distance travelled, Q8.24.
        d_d = 32'(prod_q);
        mul_a = 33'(st_q);
        mul_b = signed'({17'd0, dt_q});
        state_d = vks_pkg::ST_MUL_H2;
      end
      vks_pkg::ST_MUL_H2: begin
        mul_a = 33'(prod_q);
        mul_b = 33'(sp_q);
        state_d = vks_pkg::ST_HEAD_SUM;
      end
      vks_pkg::ST_HEAD_SUM: begin
        wrap_start = 1'b1;
        state_d = vks_pkg::ST_CORDIC_WAIT;
      end
      vks_pkg::ST_CORDIC_WAIT: begin
        if (cordic_done) begin
          state_d = vks_pkg::ST_MUL_X;
        end
      end
      vks_pkg::ST_MUL_X: begin
        mul_a = 33'(d_q);
        mul_b = cos_w;
        state_d = vks_pkg::ST_MUL_Z;
      end
      vks_pkg::ST_MUL_Z: begin
        rs = (prod_q + (66'sd1 <<< 37)) >>> 38;
        xn_d = x_q + 32'(rs);
        mul_a = 33'(d_q);
        mul_b = sin_w;
        state_d = vks_pkg::ST_Z_SUM;
      end
      vks_pkg::ST_Z_SUM: begin
        rs = (prod_q + (66'sd1 <<< 37)) >>> 38;
        zn_d = z_q + 32'(rs);
        state_d = vks_pkg::ST_FINISH;
      end
      vks_pkg::ST_FINISH: begin
        // Hold until the wrap is through and the result register is free.
        if (wrap_done && (!ovalid_q || out_ready_i)) begin
          commit = 1'b1;
          state_d = vks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vks_pkg::ST_IDLE;
      end
    endcase
    prod_d = 66'(mul_a) * 66'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vks_pkg::ST_IDLE;
      fwd_q <= 16'sd2560;
      bwd_q <= -16'sd512;
      left_q <= -16'sd7680;
      right_q <= 16'sd7680;
      speed_q <= '0;
      steer_q <= '0;
      x_q <= '0;
      z_q <= '0;
      head_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          vks_pkg::CFG_FWD_SPEED: fwd_q <= cfg_wdata_i;
          vks_pkg::CFG_BWD_SPEED: bwd_q <= cfg_wdata_i;
          vks_pkg::CFG_LEFT_STEER: left_q <= cfg_wdata_i;
          vks_pkg::CFG_RIGHT_STEER: right_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (commit) begin
        speed_q <= snap(sp_q);
        steer_q <= snap(st_q);
        x_q <= xn_q;
        z_q <= zn_q;
        head_q <= head_wrapped;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tsp_q <= target_speed_i;
      tst_q <= target_steer_i;
      dt_q <= step_time_i;
    end
    if (commit) begin
      ox_q <= xn_q;
      oz_q <= zn_q;
      ohead_q <= head_wrapped;
      ospeed_q <= snap(sp_q);
      osteer_q <= snap(st_q);
    end
    sp_q <= sp_d;
    st_q <= st_d;
    d_q <= d_d;
    xn_q <= xn_d;
    zn_q <= zn_d;
    prod_q <= prod_d;
  end

  assign out_valid_o = ovalid_q;
  assign pos_x_o = ox_q;
  assign pos_z_o = oz_q;
  assign heading_o = ohead_q;
  assign cur_speed_o = ospeed_q;
  assign cur_steer_o = osteer_q;

endmodule

@@ design/vks_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vks_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic [24:0]        heading_o,
  input logic signed [15:0] cur_speed_o
);

  `VKS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(heading_o), "result changed while stalled")
  `VKS_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after an accepted request")
  `VKS_ASSERT(a_heading_range, out_valid_o |-> heading_o <= vks_pkg::HEAD_MOD, "heading beyond a full turn")
  `VKS_ASSERT(a_speed_snap, out_valid_o |-> (cur_speed_o == 16'sd0 || cur_speed_o > 16'sd25 || cur_speed_o < -16'sd25), "speed not snapped")

endmodule

bind vehicle_kinematic_step_core vks_checker u_vks_checker (.*);

@@ tb/vehicle_kinematic_step_core_tb.sv @@
`timescale 1ns / 1ps

module vehicle_kinematic_step_core_tb;

  // Arctangent of 2^-i in Q.24 degrees, used by the predicted CORDIC rotation.
  localparam longint ATAN_TBL [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29336, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };
  localparam int     ROT_STEPS = 16;
  localparam longint GAIN_X0 = 652032874;
  localparam longint TURN = 23592960;
  localparam int     DRAIN_CYCLES = 40;
  // An index that maps to no limit register.
  localparam logic [2:0] CFG_UNUSED = 3'd5;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] z;
    logic [24:0] hdg;
    logic [15:0] spd;
    logic [15:0] str;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] target_speed_i = '0;
  logic signed [15:0] target_steer_i = '0;
  logic [15:0] step_time_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_z_o;
  logic [24:0] heading_o;
  logic signed [15:0] cur_speed_o;
  logic signed [15:0] cur_steer_o;

  vehicle_kinematic_step_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted vehicle state and limit registers.
  longint lim_fwd, lim_bwd, lim_left, lim_right;
  longint veh_speed, veh_steer, veh_head;
  logic [31:0] veh_x, veh_z;

  pose_t pose_q[$];
  int mismatches = 0;
  int rx_wait = 0;
  bit stall_random = 1'b1;

  // Floor division by 2^s that is safe for negative values.
  function automatic longint fdiv(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint round_sh(longint p, int s);
    return fdiv(p + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint bound(longint a, longint n, longint b);
    longint lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (n < lo) n = lo;
    if (n > hi) n = hi;
    return n;
  endfunction

  // Rotates the start vector by the heading; cos and sin come out Q1.30.
  task automatic heading_trig(input longint hdg, output longint c, output longint s);
    longint ang, x, y, dx, dy;
    bit flip;
    ang = hdg * 256;
    x = GAIN_X0;
    y = 0;
    flip = 1'b0;
    if (ang > (longint'(180) << 24)) ang -= longint'(360) << 24;
    if (ang > (longint'(90) << 24)) begin
      ang -= longint'(180) << 24;
      flip = 1'b1;
    end else if (ang < -(longint'(90) << 24)) begin
      ang += longint'(180) << 24;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = fdiv(y, i);
      dy = fdiv(x, i);
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; ang += ATAN_TBL[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Advances the predicted vehicle by one step and queues the expected pose.
  task automatic predict_step(input logic [15:0] tsp, input logic [15:0] tst,
                              input logic [15:0] dt_bits);
    longint sp, st, dt, c, s, travel, h, r;
    pose_t p;
    dt = longint'(dt_bits);
    sp = veh_speed + round_sh((longint'($signed(tsp)) - veh_speed) * dt * 4, 16);
    st = veh_steer + round_sh((longint'($signed(tst)) - veh_steer) * dt * 6, 16);
    sp = bound(lim_bwd, sp, lim_fwd);
    st = bound(lim_left, st, lim_right);
    heading_trig(veh_head, c, s);
    travel = sp * dt;
    veh_x = veh_x + 32'(round_sh(travel * c, 38));
    veh_z = veh_z + 32'(round_sh(travel * s, 38));
    h = veh_head + round_sh(dt * st * sp, 16);
    if (h > TURN) begin
      h = ((h - 1) % TURN) + 1;
    end else if (h < 0) begin
      r = (-h) % TURN;
      h = (r == 0) ? 0 : TURN - r;
    end
    veh_head = h;
    veh_speed = (sp >= -vks_pkg::SNAP_LIM && sp <= vks_pkg::SNAP_LIM) ? 0 : sp;
    veh_steer = (st >= -vks_pkg::SNAP_LIM && st <= vks_pkg::SNAP_LIM) ? 0 : st;
    p.x = veh_x;
    p.z = veh_z;
    p.hdg = 25'(veh_head);
    p.spd = 16'(veh_speed);
    p.str = 16'(veh_steer);
    pose_q = {pose_q, p};
  endtask

  // Sends one request, with a random gap first when stall_random is set, and predicts it on acceptance.
  // Valid stays high after acceptance until the next request or an idle wait
  // takes it down, so it is never driven twice in one time step.
  task automatic send_step(input logic [15:0] tsp, input logic [15:0] tst,
                           input logic [15:0] dt);
    int gap;
    gap = stall_random ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_speed_i <= tsp;
    target_steer_i <= tst;
    step_time_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
    predict_step(tsp, tst, dt);
  endtask

  // Waits for every queued pose plus the block's latency, so it is idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes one limit register; only called while the block is idle.
  // The caller drops the write enable after its last write.
  task automatic write_limit(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      vks_pkg::CFG_FWD_SPEED: lim_fwd = longint'($signed(val));
      vks_pkg::CFG_BWD_SPEED: lim_bwd = longint'($signed(val));
      vks_pkg::CFG_LEFT_STEER: lim_left = longint'($signed(val));
      vks_pkg::CFG_RIGHT_STEER: lim_right = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] fwd, input logic [15:0] bwd,
                            input logic [15:0] left, input logic [15:0] right);
    wait_idle();
    write_limit(vks_pkg::CFG_FWD_SPEED, fwd);
    write_limit(vks_pkg::CFG_BWD_SPEED, bwd);
    write_limit(vks_pkg::CFG_LEFT_STEER, left);
    write_limit(vks_pkg::CFG_RIGHT_STEER, right);
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes, zero step time, snap and wrap cases under reset limits.
  task automatic test_directed();
    send_step(16'h0000, 16'h0000, 16'h0000);
    send_step(16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_step(16'h8000, 16'h8000, 16'hFFFF);
    send_step(16'h7FFF, 16'h8000, 16'h0000);
    send_step(16'd20, 16'd20, 16'hFFFF);
    send_step(16'hFFEC, 16'hFFEC, 16'hFFFF);
    send_step(16'h0A00, 16'h1E00, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_step(16'h0A00, 16'h1E00, 16'hFFFF);
    send_step(16'hFE00, 16'h1E00, 16'hFFFF);
    send_step(16'hFE00, 16'hE200, 16'hFFFF);
    send_step(16'h0000, 16'h0000, 16'h0001);
    send_step(16'h5555, 16'hAAAA, 16'h5555);
    send_step(16'hAAAA, 16'h5555, 16'hAAAA);
  endtask

  // Bounds in reversed order, equal bounds and full-range bounds.
  task automatic test_limits();
    set_limits(16'hFE00, 16'h0A00, 16'h1E00, 16'hE200);
    for (int i = 0; i < 4; i++) send_step(16'h7FFF, 16'h8000, 16'hFFFF);
    set_limits(16'h0100, 16'h0100, 16'h0500, 16'h0500);
    for (int i = 0; i < 3; i++) send_step(16'h8000, 16'h7FFF, 16'h8000);
    set_limits(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    for (int i = 0; i < 3; i++) send_step(16'h7FFF, 16'h7FFF, 16'hFFFF);
    // Unused register index must be ignored by the block.
    wait_idle();
    write_limit(CFG_UNUSED, 16'h1234);
    cfg_we_i <= 1'b0;
  endtask

  // Random drive: mostly realistic commands, with occasional full-range noise.
  task automatic test_random(input int count);
    logic [15:0] tsp, tst, dt;
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 399) begin
        case ($urandom_range(0, 2))
          0: set_limits(16'h0A00, 16'hFE00, 16'hE200, 16'h1E00);
          1: set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          default: set_limits(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        tsp = 16'($urandom);
        tst = 16'($urandom);
        dt = 16'($urandom);
      end else begin
        tsp = 16'($signed(16'($urandom_range(0, 4095))) - 16'sd1024);
        tst = 16'($urandom_range(0, 16383) - 8192);
        dt = 16'($urandom_range(0, 8191));
      end
      if (i == count / 2) begin
        // Hold the sender until the block has delivered everything pending.
        in_valid_i <= 1'b0;
        while (pose_q.size() != 0) @(posedge clk_i);
      end
      stall_random = ((i / 100) % 4) != 3;
      send_step(tsp, tst, dt);
    end
    stall_random = 1'b1;
  endtask

  // Receiver: compares each accepted pose, then draws a random wait before the next while stall_random is set.
  always @(posedge clk_i) begin
    pose_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose with nothing pending");
      end else begin
        want = pose_q.pop_front();
        if (pos_x_o !== want.x || pos_z_o !== want.z || heading_o !== want.hdg ||
            cur_speed_o !== want.spd || cur_steer_o !== want.str) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: exp x=%h z=%h h=%h sp=%h st=%h got %h %h %h %h %h",
                     want.x, want.z, want.hdg, want.spd, want.str,
                     pos_x_o, pos_z_o, heading_o, cur_speed_o, cur_steer_o);
        end
      end
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rx_wait = stall_random ? $urandom_range(0, 17) : 0;
        out_ready_i <= (rx_wait == 0);
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= (rx_wait == 0);
      end else if (rx_wait == 0) begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    lim_fwd = 2560; lim_bwd = -512; lim_left = -7680; lim_right = 7680;
    veh_speed = 0; veh_steer = 0; veh_head = 0; veh_x = '0; veh_z = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    set_limits(16'h0A00, 16'hFE00, 16'hE200, 16'h1E00);
    test_random(1620);
    wait_idle();
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("vehicle_kinematic_step_core_tb passed");
    end else begin
      $display("vehicle_kinematic_step_core_tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("vehicle_kinematic_step_core_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/vks_pkg.sv
design/vks_cordic.sv
design/vks_wrap.sv
design/vehicle_kinematic_step_core.sv
design/vks_checker.sv
tb/vehicle_kinematic_step_core_tb.sv
